FILE: rtl/assert_macros.svh
// assertion helpers shared by the parser rtl
// no dependencies; included by the files that carry checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define TPPD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("tppd assertion failed");

// condition that must never be seen out of reset
`define TPPD_ASSERT_NEVER(lbl, clk, rstn, cond) \
  `TPPD_ASSERT(lbl, clk, rstn, !(cond))

`endif

FILE: rtl/tppd_pkg.sv
// shared constants, types and field parsing for the touch packet parser
// no dependencies
package tppd_pkg;

  localparam int unsigned MaxLenDefault = 16;
  localparam int unsigned YStartDefault = 6;
  localparam int unsigned CoordW        = 14;
  localparam int unsigned QueueDepth    = 2;

  localparam logic [7:0] CrByte      = 8'h0D;
  localparam logic [7:0] TouchByte   = 8'h54;
  localparam logic [7:0] ReleaseByte = 8'h52;
  localparam logic [7:0] JitterReset = 8'd3;

  localparam logic [CoordW-1:0] CoordMax = {CoordW{1'b1}};

  // field parse phase
  localparam logic [1:0] PhaseWait   = 2'd0;
  localparam logic [1:0] PhaseDigits = 2'd1;
  localparam logic [1:0] PhaseDone   = 2'd2;

  typedef logic [CoordW-1:0] coord_t;

  typedef struct packed {
    coord_t     acc;
    logic [1:0] phase;
  } field_t;

  // one complete packet handed from parser to filter
  typedef struct packed {
    logic   touch;
    coord_t px;
    coord_t py;
  } pkt_t;

  function automatic field_t feed_field(field_t f, logic [7:0] b);
    field_t              r;
    logic [CoordW+3:0]   v;
    r = f;
    v = ({4'b0, f.acc} * (CoordW + 4)'(10)) + {{(CoordW){1'b0}}, b[3:0]};
    if (f.phase == PhaseDone) begin
      r = f;
    end else if (b inside {[8'h30:8'h39]}) begin
      r.acc   = (v > {4'b0, CoordMax}) ? CoordMax : v[CoordW-1:0];
      r.phase = PhaseDigits;
    end else if (f.phase == PhaseWait && b inside {8'h20, [8'h09:8'h0D]}) begin
      r = f;
    end else begin
      r.phase = PhaseDone;
    end
    return r;
  endfunction

endpackage

FILE: rtl/tppd_intf.sv
// handshake channels of the touch packet parser: byte in, position out
// depends on tppd_pkg
interface tppd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface tppd_pos_if;
  logic                 valid;
  logic                 ready;
  tppd_pkg::coord_t     pos_x;
  tppd_pkg::coord_t     pos_y;
  logic                 touch_down;
  modport source (output valid, output pos_x, output pos_y, output touch_down, input ready);
  modport sink (input valid, input pos_x, input pos_y, input touch_down, output ready);
endinterface

FILE: rtl/touch_packet_parser_deadband.sv
// top level of the serial touch packet parser with jitter dead band
// depends on tppd_pkg, tppd_intf, tppd_front, tppd_queue, tppd_back
//
// usage: rx_i takes one serial byte per request (valid/ready); a packet runs up
// to a carriage return, its first byte 'T' (touch) or 'R' (release), X digits
// from byte 1 and Y digits from byte Y_START. pos_o gives one request per
// reported position (pos_x, pos_y, touch_down). cfg_we_i/cfg_wdata_i set the
// jitter threshold; write it only while no packet is in flight.
// throughput: one byte per cycle while the packet queue has room; the parser
// handles each byte in the cycle it is taken. a packet's result passes from
// the parser, which handles its carriage return, through the packet queue into
// the filter's output register. packets that are dropped or fall inside the
// dead band give no request.
// stalls: the output register holds a result until pos_o.ready; the two-entry
// packet queue keeps taking packets meanwhile, and rx_i.ready drops only while
// the queue is full.
// reset: rst_ni clears the packet state, last position and pen state and sets
// the threshold to 3; rx_i is ready in the first cycle after reset.
module touch_packet_parser_deadband #(
  parameter int unsigned MAX_LEN = tppd_pkg::MaxLenDefault,
  parameter int unsigned Y_START = tppd_pkg::YStartDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [7:0]   cfg_wdata_i,
  tppd_byte_if.sink    rx_i,
  tppd_pos_if.source   pos_o
);

  logic           push_valid, push_ready, pop_valid, pop_ready;
  tppd_pkg::pkt_t push_pkt, pop_pkt;

  tppd_front #(
    .MAX_LEN (MAX_LEN),
    .Y_START (Y_START)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rx_i         (rx_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_pkt_o   (push_pkt)
  );

  tppd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_pkt_i   (push_pkt),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_pkt_o    (pop_pkt)
  );

  tppd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_pkt_i   (pop_pkt),
    .pos_o       (pos_o)
  );

endmodule

FILE: rtl/tppd_front.sv
// byte parser: tracks packet position, lead byte and both decimal fields
// depends on tppd_pkg, tppd_intf, assert_macros.svh
`include "assert_macros.svh"

module tppd_front #(
  parameter int unsigned MAX_LEN = tppd_pkg::MaxLenDefault,
  parameter int unsigned Y_START = tppd_pkg::YStartDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  tppd_byte_if.sink          rx_i,
  output logic               push_valid_o,
  input  logic               push_ready_i,
  output tppd_pkg::pkt_t     push_pkt_o
);

  localparam int unsigned PosW = $clog2(MAX_LEN + 1);

  logic [PosW-1:0]  pos_q, pos_d;
  logic [7:0]       lead_q, lead_d;
  tppd_pkg::field_t x_q, x_d, y_q, y_d;
  tppd_pkg::field_t x_fed, y_fed;
  logic [7:0]       lead_new;
  logic             accept, end_pkt;

  assign rx_i.ready = push_ready_i;
  assign accept     = rx_i.valid && rx_i.ready;
  assign end_pkt    = accept && (rx_i.rx_byte == tppd_pkg::CrByte);

  always_comb begin
    x_fed    = x_q;
    y_fed    = y_q;
    lead_new = lead_q;
    pos_d    = pos_q;
    if (pos_q < PosW'(MAX_LEN)) begin
      if (pos_q == '0) begin
        lead_new = rx_i.rx_byte;
      end
      if (pos_q >= PosW'(1)) begin
        x_fed = tppd_pkg::feed_field(x_q, rx_i.rx_byte);
      end
      if (pos_q >= PosW'(Y_START)) begin
        y_fed = tppd_pkg::feed_field(y_q, rx_i.rx_byte);
      end
      pos_d = pos_q + PosW'(1);
    end

    lead_d = lead_new;
    x_d    = x_fed;
    y_d    = y_fed;
    if (end_pkt) begin
      pos_d  = '0;
      lead_d = '0;
      x_d    = '{acc: '0, phase: tppd_pkg::PhaseWait};
      y_d    = '{acc: '0, phase: tppd_pkg::PhaseWait};
    end else if (!accept) begin
      pos_d  = pos_q;
      lead_d = lead_q;
      x_d    = x_q;
      y_d    = y_q;
    end
  end

  // only touch and release packets go on to the filter
  assign push_valid_o = end_pkt &&
                        (lead_new == tppd_pkg::TouchByte || lead_new == tppd_pkg::ReleaseByte);
  assign push_pkt_o   = '{touch: (lead_new == tppd_pkg::TouchByte),
                          px: x_fed.acc, py: y_fed.acc};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      lead_q <= '0;
      x_q    <= '{acc: '0, phase: tppd_pkg::PhaseWait};
      y_q    <= '{acc: '0, phase: tppd_pkg::PhaseWait};
    end else begin
      pos_q  <= pos_d;
      lead_q <= lead_d;
      x_q    <= x_d;
      y_q    <= y_d;
    end
  end

  `TPPD_ASSERT_NEVER(a_pos_bound, clk_i, rst_ni, pos_q > PosW'(MAX_LEN))

endmodule

FILE: rtl/tppd_queue.sv
// two-entry packet queue between parser and jitter filter
// depends on tppd_pkg, assert_macros.svh
`include "assert_macros.svh"

module tppd_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  tppd_pkg::pkt_t  push_pkt_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output tppd_pkg::pkt_t  pop_pkt_o
);

  localparam int unsigned Depth = tppd_pkg::QueueDepth;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  tppd_pkg::pkt_t  mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            push, pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_pkt_o    = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  function automatic logic [PtrW-1:0] next_ptr(logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_pkt_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (pop) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (push && !pop) begin
        count_q <= count_q + CntW'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  // the parser must hold a packet end back while the queue is full
  `TPPD_ASSERT_NEVER(a_no_push_full, clk_i, rst_ni, push_valid_i && !push_ready_o)

endmodule

FILE: rtl/tppd_back.sv
// jitter filter: compares packets against the last reported position
// depends on tppd_pkg, tppd_intf, assert_macros.svh
`include "assert_macros.svh"

module tppd_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [7:0]      cfg_wdata_i,
  input  logic            pop_valid_i,
  output logic            pop_ready_o,
  input  tppd_pkg::pkt_t  pop_pkt_i,
  tppd_pos_if.source      pos_o
);

  logic [7:0]       thr_q;
  tppd_pkg::coord_t last_x_q, last_y_q;
  tppd_pkg::coord_t out_x_q, out_y_q;
  logic             out_touch_q;
  logic             out_valid_q;
  tppd_pkg::coord_t dx, dy, thr_ext;
  logic             pop, suppress;

  assign pop_ready_o = !out_valid_q || pos_o.ready;
  assign pop         = pop_valid_i && pop_ready_o;

  assign dx      = (pop_pkt_i.px > last_x_q) ? pop_pkt_i.px - last_x_q : last_x_q - pop_pkt_i.px;
  assign dy      = (pop_pkt_i.py > last_y_q) ? pop_pkt_i.py - last_y_q : last_y_q - pop_pkt_i.py;
  assign thr_ext = {{(tppd_pkg::CoordW - 8){1'b0}}, thr_q};
  // release always reports, touch only outside the dead band
  assign suppress = pop_pkt_i.touch && (dx < thr_ext) && (dy < thr_ext);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q       <= tppd_pkg::JitterReset;
      last_x_q    <= '0;
      last_y_q    <= '0;
      out_valid_q <= 1'b0;
      out_touch_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      if (pop) begin
        out_valid_q <= !suppress;
        if (!suppress) begin
          last_x_q    <= pop_pkt_i.px;
          last_y_q    <= pop_pkt_i.py;
          out_touch_q <= pop_pkt_i.touch;
        end
      end else if (pos_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && !suppress) begin
      out_x_q <= pop_pkt_i.px;
      out_y_q <= pop_pkt_i.py;
    end
  end

  assign pos_o.valid      = out_valid_q;
  assign pos_o.pos_x      = out_x_q;
  assign pos_o.pos_y      = out_y_q;
  assign pos_o.touch_down = out_touch_q;

  `TPPD_ASSERT(a_release_reports, clk_i, rst_ni, (pop && !pop_pkt_i.touch) |=> (out_valid_q && !out_touch_q))

endmodule
